>>> src/spectrum_bin_band_accumulator_core_macros.svh
// Assertion macros for the spectrum bin band accumulator checker.
// Used by the checker file; depends on nothing else.
`ifndef SPECTRUM_BIN_BAND_ACCUMULATOR_CORE_MACROS_SVH
`define SPECTRUM_BIN_BAND_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sbba_pkg.sv
// Shared types and constants of the spectrum bin band accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package sbba_pkg;

   localparam int NUM_BANDS = 8;
   localparam int FFT_SIZE  = 1024;
   localparam int BIN_FIRST = 2;

   localparam int IDX_W  = 10;
   localparam int MAG_W  = 32;
   localparam int SUM_W  = 48;
   localparam int BW_W   = 16;
   localparam int EDGE_W = 16;
   localparam int NB_W   = 4;
   localparam int BAND_W = 3;
   localparam int FREQ_W = IDX_W + BW_W;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [IDX_W-1:0] BIN_LO = IDX_W'(BIN_FIRST);
   localparam logic [IDX_W-1:0] BIN_HI = IDX_W'(FFT_SIZE / 2);
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH_HZ    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BANDS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_EDGES_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_EDGES_HIGH = 3'd4;

   localparam logic [MAG_W-1:0] RST_NOISE_THRESHOLD = 32'd1000;
   localparam logic [BW_W-1:0]  RST_BIN_WIDTH_HZ    = 16'd43;
   localparam logic [NB_W-1:0]  RST_NUM_BANDS       = 4'd8;

   typedef struct packed {
      logic              load_item;
      logic              do_mult;
      logic              do_accum;
      logic              emit_load;
      logic              emit_last;
      logic              clear_sums;
      logic [BAND_W-1:0] band_sel;
   } sbba_cmd_type;

   typedef struct packed {
      logic              item_eof;
      logic              out_free;
      logic [BAND_W-1:0] last_band;
   } sbba_sts_type;

endpackage

>>> src/spectrum_bin_band_accumulator_core.sv
// Spectrum bin band accumulator, top level.
// Channels: req_ takes one FFT bin per transfer (tdata: bin index, magnitude;
// tlast: end of frame). rsp_ returns one band sum per transfer (tdata: band
// number, 48-bit sum; tlast: last band of the frame). csr_ writes the noise
// threshold, bin width, band count and the two band edge words.
// Each bin passes three steps: one takes it in, one forms the bin
// frequency in the multiplier, one compares it against all band edges and
// updates the saturating sums in parallel. A new bin is accepted only once
// the previous one is through. On a bin with tlast the bands are read out
// afterwards, one per cycle while the receiver takes them. The first band
// sum follows the item, frequency and sum registers into the result register.
// The result register lets the next bin be taken while the final band waits.
// If the receiver stalls, readout pauses and req_tready stays low until the
// last band sits in the result register; the sums are then cleared.
// Reset clears the sums and loads the register reset values.
// Depends on sbba_pkg, sbba_ctrl and sbba_dp.
module spectrum_bin_band_accumulator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [sbba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: bin_index[9:0], magnitude[41:10], zero padding.
   input  logic [sbba_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: band_number[2:0], band_sum[50:3], zero padding.
   output logic [sbba_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);

   sbba_pkg::sbba_cmd_type cmd;
   sbba_pkg::sbba_sts_type sts;

   sbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sbba_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/sbba_ctrl.sv
// Controller of the spectrum bin band accumulator: item sequencing and band readout.
// Depends on sbba_pkg; drives the datapath sbba_dp through command signals.
module sbba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sbba_pkg::sbba_sts_type sts,
   output sbba_pkg::sbba_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [sbba_pkg::BAND_W-1:0]   band_ff, band_in;
   logic                          at_last;

   assign at_last = (band_ff == sts.last_band);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      cmd      = '0;
      cmd.band_sel  = band_ff;
      cmd.emit_last = at_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.do_mult = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.do_accum = 1'b1;
            band_in      = '0;
            state_in     = sts.item_eof ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // One band goes to the output register each time it is free.
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (at_last) begin
                  cmd.clear_sums = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  band_in = band_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
      end
   end

endmodule

>>> src/sbba_dp.sv
// Datapath of the spectrum bin band accumulator: registers, bin frequency,
// band compare, saturating sums and result register. Depends on sbba_pkg.
module sbba_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  sbba_pkg::sbba_cmd_type             cmd,
   output sbba_pkg::sbba_sts_type             sts,
   input  logic                               csr_wr_en,
   input  logic [sbba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [sbba_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sbba_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int NB = sbba_pkg::NUM_BANDS;
   localparam int PAD_W = sbba_pkg::RSP_TDATA_W - sbba_pkg::SUM_W - sbba_pkg::BAND_W;

   logic [sbba_pkg::MAG_W-1:0]      thr_ff;
   logic [sbba_pkg::BW_W-1:0]       bw_ff;
   logic [sbba_pkg::NB_W-1:0]       nb_ff;
   logic [sbba_pkg::CSR_DATA_W-1:0] edges_lo_ff, edges_hi_ff;

   logic [sbba_pkg::IDX_W-1:0]  idx_ff;
   logic [sbba_pkg::MAG_W-1:0]  mag_ff;
   logic                        eof_ff;
   logic [sbba_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic                        counted_ff, counted_in;

   logic [sbba_pkg::SUM_W-1:0]  sums_ff [NB];
   logic [sbba_pkg::SUM_W-1:0]  sums_in [NB];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sbba_pkg::BAND_W-1:0] rsp_band_ff;
   logic [sbba_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic                        rsp_last_ff;

   logic [2*sbba_pkg::CSR_DATA_W-1:0] edge_word;
   logic [sbba_pkg::EDGE_W-1:0]       edge_val [NB];
   logic [sbba_pkg::BAND_W-1:0]       last_band;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= sbba_pkg::RST_NOISE_THRESHOLD;
         bw_ff       <= sbba_pkg::RST_BIN_WIDTH_HZ;
         nb_ff       <= sbba_pkg::RST_NUM_BANDS;
         edges_lo_ff <= '0;
         edges_hi_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sbba_pkg::CSR_NOISE_THRESHOLD: thr_ff <= csr_wdata[sbba_pkg::MAG_W-1:0];
            sbba_pkg::CSR_BIN_WIDTH_HZ:    bw_ff <= csr_wdata[sbba_pkg::BW_W-1:0];
            sbba_pkg::CSR_NUM_BANDS:       nb_ff <= csr_wdata[sbba_pkg::NB_W-1:0];
            sbba_pkg::CSR_BAND_EDGES_LOW:  edges_lo_ff <= csr_wdata;
            sbba_pkg::CSR_BAND_EDGES_HIGH: edges_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A band count of zero behaves as one band; counts above the band total clamp.
   always_comb begin
      if (nb_ff == '0) begin
         last_band = '0;
      end else if (nb_ff > sbba_pkg::NB_W'(NB)) begin
         last_band = sbba_pkg::BAND_W'(NB - 1);
      end else begin
         last_band = sbba_pkg::BAND_W'(nb_ff - 1'b1);
      end
   end

   assign edge_word = {edges_hi_ff, edges_lo_ff};
   always_comb begin
      for (int b = 0; b < NB; b++) begin
         edge_val[b] = edge_word[b*sbba_pkg::EDGE_W +: sbba_pkg::EDGE_W];
      end
   end

   assign freq_in    = sbba_pkg::FREQ_W'(idx_ff) * sbba_pkg::FREQ_W'(bw_ff);
   assign counted_in = (idx_ff >= sbba_pkg::BIN_LO) && (idx_ff < sbba_pkg::BIN_HI)
                       && (mag_ff > thr_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         idx_ff <= req_tdata[sbba_pkg::IDX_W-1:0];
         mag_ff <= req_tdata[sbba_pkg::IDX_W +: sbba_pkg::MAG_W];
         eof_ff <= req_tlast;
      end
      if (cmd.do_mult) begin
         freq_ff    <= freq_in;
         counted_ff <= counted_in;
      end
   end

   always_comb begin
      logic [sbba_pkg::FREQ_W-1:0] lo, hi;
      logic [sbba_pkg::SUM_W:0]    sum_ext;
      for (int b = 0; b < NB; b++) begin
         lo = (b == 0) ? '0 : sbba_pkg::FREQ_W'(edge_val[(b == 0) ? 0 : b - 1]);
         hi = sbba_pkg::FREQ_W'(edge_val[b]);
         sum_ext = {1'b0, sums_ff[b]} + (sbba_pkg::SUM_W + 1)'(mag_ff);
         sums_in[b] = sums_ff[b];
         if (cmd.clear_sums) begin
            sums_in[b] = '0;
         end else if (cmd.do_accum && counted_ff && (sbba_pkg::BAND_W'(b) <= last_band)
                      && (freq_ff > lo) && (freq_ff <= hi)) begin
            sums_in[b] = sum_ext[sbba_pkg::SUM_W] ? sbba_pkg::SUM_MAX
                                                  : sum_ext[sbba_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NB; b++) begin
         if (reset) begin
            sums_ff[b] <= '0;
         end else begin
            sums_ff[b] <= sums_in[b];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit_load) begin
         rsp_band_ff <= cmd.band_sel;
         rsp_sum_ff  <= sums_ff[cmd.band_sel];
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_sum_ff, rsp_band_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign sts.item_eof  = eof_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign sts.last_band = last_band;

endmodule

>>> src/sbba_checker.sv
// Port-level checker for the spectrum bin band accumulator, bound to the top level.
// Depends on sbba_pkg and the assertion macros header.
`include "spectrum_bin_band_accumulator_core_macros.svh"

module sbba_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sbba_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tlast
);

   logic                             rsp_wait;
   logic                             req_xfer;
   logic                             rsp_top;
   logic                             rsp_mid;
   logic [sbba_pkg::RSP_TDATA_W:0]   rsp_word;

   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_top  = rsp_tvalid && (rsp_tdata[sbba_pkg::BAND_W-1:0]
                                    == sbba_pkg::BAND_W'(sbba_pkg::NUM_BANDS - 1));
   assign rsp_mid  = rsp_tvalid && !rsp_tlast;
   assign rsp_word = {rsp_tlast, rsp_tdata};

   // A stalled result keeps its contents.
   `SBBA_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_tvalid && $stable(rsp_word), "held result changed")

   // After each bin transfer, req_tready drops.
   `SBBA_ASSERT_NEXT(a_req_busy, req_xfer, !req_tready, "bin taken on back-to-back cycles")

   // The highest band number always closes a frame.
   `SBBA_ASSERT_NOW(a_band_top_last, rsp_top, rsp_tlast, "top band without last flag")

   // While a frame is still being read out, no new bin is taken.
   `SBBA_ASSERT_NOW(a_readout_blocks, rsp_mid, !req_tready, "bin taken during band readout")

endmodule

bind spectrum_bin_band_accumulator_core sbba_checker u_checker (.*);
